// ===== rtl/core/banded_nearest_point_gain_lookup_assert.svh =====
// Assertion macros for the banded nearest point gain lookup.
`ifndef BANDED_NEAREST_POINT_GAIN_LOOKUP_ASSERT_SVH
`define BANDED_NEAREST_POINT_GAIN_LOOKUP_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define BNPGL_ASSERT_NOW(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Check a consequence in the same cycle.
`define BNPGL_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the next cycle.
`define BNPGL_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/bnpgl_pkg.sv =====
// Package with command codes, status codes and state type of the gain lookup.
`timescale 1ns / 1ps
package bnpgl_pkg;

   localparam logic [2:0] CMD_ADD_BAND  = 3'd0;
   localparam logic [2:0] CMD_ATTACH    = 3'd1;
   localparam logic [2:0] CMD_ADD_POINT = 3'd2;
   localparam logic [2:0] CMD_QUERY     = 3'd3;
   localparam logic [2:0] CMD_CLEAR     = 3'd4;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAND_FULL  = 3'd1;
   localparam logic [2:0] ST_TABLE_FULL = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
   localparam logic [2:0] ST_BAD_BAND   = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_BAND_CHK,
      S_PT_CHK,
      S_EMIT
   } state_type;

endpackage

// ===== rtl/core/bnpgl_req_if.sv =====
// Request channel interface of the gain lookup.
`timescale 1ns / 1ps
interface bnpgl_req_if;
   logic               valid;
   logic               ready;
   logic        [2:0]  cmd;
   logic        [2:0]  band_index;
   logic signed [31:0] lower_edge;
   logic signed [31:0] upper_edge;
   logic signed [31:0] point_freq;
   logic signed [15:0] point_gain;
   logic signed [31:0] query_freq;

   modport source (output valid, cmd, band_index, lower_edge, upper_edge, point_freq,
                   point_gain, query_freq, input ready);
   modport sink (input valid, cmd, band_index, lower_edge, upper_edge, point_freq,
                 point_gain, query_freq, output ready);
endinterface

// ===== rtl/core/bnpgl_rsp_if.sv =====
// Response channel interface of the gain lookup.
`timescale 1ns / 1ps
interface bnpgl_rsp_if;
   logic               valid;
   logic               ready;
   logic        [2:0]  status;
   logic signed [15:0] gain;
   logic signed [31:0] matched_freq;

   modport source (output valid, status, gain, matched_freq, input ready);
   modport sink (input valid, status, gain, matched_freq, output ready);
endinterface

// ===== rtl/core/bnpgl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module bnpgl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/banded_nearest_point_gain_lookup.sv =====
// Banded nearest point gain lookup: band list, point tables and query engine.
//
//   channel   dir   handshake        payload
//   req_ch    in    valid / ready    cmd, band_index, edges, point, query_freq
//   rsp_ch    out   valid / ready    status, gain, matched_freq
//
// A non-query item, or a query with no bands, goes from accept through S_EXEC to S_EMIT,
// which waits until the response slot is free. A query otherwise does one band memory
// read per band scanned and one point memory read per point walked before S_EMIT.
// Reset and clear all empty the band list at once; memories need no clearing.
// A new item is taken while the previous response still waits on rsp_ch.ready.
`timescale 1ns / 1ps
`include "banded_nearest_point_gain_lookup_assert.svh"
module banded_nearest_point_gain_lookup #(
   parameter int MAX_BANDS  = 8,
   parameter int MAX_POINTS = 64
) (
   input logic          clock,
   input logic          reset,
   bnpgl_req_if.sink    req_ch,
   bnpgl_rsp_if.source  rsp_ch
);
   import bnpgl_pkg::*;

   localparam int BAW    = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
   localparam int BTW    = $clog2(MAX_BANDS + 1);
   localparam int CMPW   = (BTW > 3) ? BTW : 3;
   localparam int PKW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int PCW    = $clog2(MAX_POINTS + 1);
   localparam int PDEPTH = MAX_BANDS * MAX_POINTS;
   localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

   state_type          state_ff, state_in;

   logic        [2:0]  cmd_ff, cmd_in;
   logic        [2:0]  bi_ff, bi_in;
   logic signed [31:0] lo_ff, lo_in;
   logic signed [31:0] hi_ff, hi_in;
   logic signed [31:0] pf_ff, pf_in;
   logic signed [15:0] pg_ff, pg_in;
   logic signed [31:0] q_ff, q_in;

   logic [BTW-1:0]       band_total_ff, band_total_in;
   logic [MAX_BANDS-1:0] has_ff, has_in;
   logic [PCW-1:0]       cnt_ff [MAX_BANDS];
   logic [PCW-1:0]       cnt_in [MAX_BANDS];

   logic [BAW-1:0]     scan_ff, scan_in;
   logic [PKW-1:0]     pt_k_ff, pt_k_in;
   logic signed [31:0] prev_f_ff, prev_f_in;
   logic signed [15:0] prev_g_ff, prev_g_in;
   logic signed [32:0] dprev_ff, dprev_in;

   logic        [2:0]  res_status_ff, res_status_in;
   logic signed [15:0] res_gain_ff, res_gain_in;
   logic signed [31:0] res_freq_ff, res_freq_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic        [2:0]  rsp_status_ff, rsp_status_in;
   logic signed [15:0] rsp_gain_ff, rsp_gain_in;
   logic signed [31:0] rsp_freq_ff, rsp_freq_in;

   logic           band_wr_en, band_rd_en;
   logic [BAW-1:0] band_wr_addr, band_rd_addr;
   logic [63:0]    band_rd_data;
   logic           pt_wr_en, pt_rd_en;
   logic [PAW-1:0] pt_wr_addr, pt_rd_addr;
   logic [47:0]    pt_rd_data;

   logic               req_fire;
   logic               slot_free;
   logic [BAW-1:0]     sel_band;
   logic               has_sel;
   logic [PCW-1:0]     cnt_sel;
   logic               bi_bad;
   logic               band_full;
   logic signed [31:0] band_lo, band_hi;
   logic               band_hit;
   logic               band_last;
   logic [PAW-1:0]     pt_base;
   logic signed [31:0] pt_f;
   logic signed [15:0] pt_g;
   logic               pt_above, pt_equal, pt_last;
   logic signed [32:0] dnext;
   logic               pick_cur;

   bnpgl_ram #(.WIDTH(64), .DEPTH(MAX_BANDS)) u_band_ram (
      .clock   (clock),
      .wr_en   (band_wr_en),
      .wr_addr (band_wr_addr),
      .wr_data ({hi_ff, lo_ff}),
      .rd_en   (band_rd_en),
      .rd_addr (band_rd_addr),
      .rd_data (band_rd_data)
   );

   bnpgl_ram #(.WIDTH(48), .DEPTH(PDEPTH)) u_point_ram (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (pt_wr_addr),
      .wr_data ({pf_ff, pg_ff}),
      .rd_en   (pt_rd_en),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   assign sel_band  = (state_ff == S_EXEC) ? BAW'(bi_ff) : scan_ff;
   assign has_sel   = has_ff[sel_band];
   assign cnt_sel   = cnt_ff[sel_band];
   assign bi_bad    = CMPW'(bi_ff) >= CMPW'(band_total_ff);
   assign band_full = band_total_ff == BTW'(MAX_BANDS);

   assign band_lo   = band_rd_data[31:0];
   assign band_hi   = band_rd_data[63:32];
   assign band_hit  = (q_ff >= band_lo) && (q_ff <= band_hi);
   assign band_last = (BTW'(scan_ff) + BTW'(1)) == band_total_ff;

   assign pt_base   = PAW'(PAW'(sel_band) * PAW'(MAX_POINTS));
   assign pt_f      = pt_rd_data[47:16];
   assign pt_g      = pt_rd_data[15:0];
   assign pt_above  = pt_f > q_ff;
   assign pt_equal  = pt_f == q_ff;
   assign pt_last   = (PCW'(pt_k_ff) + PCW'(1)) == cnt_sel;
   assign dnext     = {pt_f[31], pt_f} - {q_ff[31], q_ff};
   assign pick_cur  = (pt_k_ff == '0) || (dprev_ff > dnext);

   assign req_ch.ready        = state_ff == S_IDLE;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.gain         = rsp_gain_ff;
   assign rsp_ch.matched_freq = rsp_freq_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd_ff == CMD_QUERY && band_total_ff != '0) begin
               state_in = S_BAND_CHK;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_BAND_CHK: begin
            if (band_hit) begin
               state_in = (!has_sel || cnt_sel == '0) ? S_EMIT : S_PT_CHK;
            end else if (band_last) begin
               state_in = S_EMIT;
            end
         end
         S_PT_CHK: begin
            if (pt_above || pt_equal || pt_last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      bi_in         = bi_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      pf_in         = pf_ff;
      pg_in         = pg_ff;
      q_in          = q_ff;
      band_total_in = band_total_ff;
      has_in        = has_ff;
      cnt_in        = cnt_ff;
      scan_in       = scan_ff;
      pt_k_in       = pt_k_ff;
      prev_f_in     = prev_f_ff;
      prev_g_in     = prev_g_ff;
      dprev_in      = dprev_ff;
      res_status_in = res_status_ff;
      res_gain_in   = res_gain_ff;
      res_freq_in   = res_freq_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_gain_in   = rsp_gain_ff;
      rsp_freq_in   = rsp_freq_ff;
      band_wr_en    = 1'b0;
      band_wr_addr  = BAW'(band_total_ff);
      band_rd_en    = 1'b0;
      band_rd_addr  = '0;
      pt_wr_en      = 1'b0;
      pt_wr_addr    = pt_base + PAW'(cnt_sel);
      pt_rd_en      = 1'b0;
      pt_rd_addr    = pt_base;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in = req_ch.cmd;
               bi_in  = req_ch.band_index;
               lo_in  = req_ch.lower_edge;
               hi_in  = req_ch.upper_edge;
               pf_in  = req_ch.point_freq;
               pg_in  = req_ch.point_gain;
               q_in   = req_ch.query_freq;
            end
         end
         S_EXEC: begin
            res_status_in = ST_OK;
            res_gain_in   = '0;
            res_freq_in   = '0;
            unique case (cmd_ff)
               CMD_ADD_BAND: begin
                  if (band_full) begin
                     res_status_in = ST_BAND_FULL;
                  end else begin
                     band_wr_en = 1'b1;
                     has_in[BAW'(band_total_ff)] = 1'b0;
                     cnt_in[BAW'(band_total_ff)] = '0;
                     band_total_in = band_total_ff + BTW'(1);
                  end
               end
               CMD_ATTACH: begin
                  if (bi_bad) begin
                     res_status_in = ST_BAD_BAND;
                  end else begin
                     has_in[sel_band] = 1'b1;
                  end
               end
               CMD_ADD_POINT: begin
                  if (bi_bad || !has_sel) begin
                     res_status_in = ST_BAD_BAND;
                  end else if (cnt_sel == PCW'(MAX_POINTS)) begin
                     res_status_in = ST_TABLE_FULL;
                  end else begin
                     pt_wr_en         = 1'b1;
                     cnt_in[sel_band] = cnt_sel + PCW'(1);
                  end
               end
               CMD_QUERY: begin
                  if (band_total_ff == '0) begin
                     res_status_in = ST_NOT_FOUND;
                  end else begin
                     scan_in      = '0;
                     band_rd_en   = 1'b1;
                     band_rd_addr = '0;
                  end
               end
               CMD_CLEAR: begin
                  band_total_in = '0;
                  has_in        = '0;
                  cnt_in        = '{default: '0};
               end
               default: begin
                  res_status_in = ST_OK;
               end
            endcase
         end
         S_BAND_CHK: begin
            if (band_hit) begin
               if (!has_sel) begin
                  res_status_in = ST_NOT_FOUND;
               end else if (cnt_sel != '0) begin
                  pt_k_in    = '0;
                  pt_rd_en   = 1'b1;
                  pt_rd_addr = pt_base;
               end
            end else if (band_last) begin
               res_status_in = ST_NOT_FOUND;
            end else begin
               scan_in      = scan_ff + BAW'(1);
               band_rd_en   = 1'b1;
               band_rd_addr = scan_ff + BAW'(1);
            end
         end
         S_PT_CHK: begin
            if (pt_above) begin
               res_gain_in = pick_cur ? pt_g : prev_g_ff;
               res_freq_in = pick_cur ? pt_f : prev_f_ff;
            end else if (pt_equal || pt_last) begin
               res_gain_in = pt_g;
               res_freq_in = pt_f;
            end else begin
               prev_f_in  = pt_f;
               prev_g_in  = pt_g;
               dprev_in   = {q_ff[31], q_ff} - {pt_f[31], pt_f};
               pt_k_in    = pt_k_ff + PKW'(1);
               pt_rd_en   = 1'b1;
               pt_rd_addr = pt_base + PAW'(pt_k_ff) + PAW'(1);
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_gain_in   = res_gain_ff;
               rsp_freq_in   = res_freq_ff;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         band_total_ff <= '0;
         has_ff        <= '0;
         cnt_ff        <= '{default: '0};
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         band_total_ff <= band_total_in;
         has_ff        <= has_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      bi_ff         <= bi_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      pf_ff         <= pf_in;
      pg_ff         <= pg_in;
      q_ff          <= q_in;
      scan_ff       <= scan_in;
      pt_k_ff       <= pt_k_in;
      prev_f_ff     <= prev_f_in;
      prev_g_ff     <= prev_g_in;
      dprev_ff      <= dprev_in;
      res_status_ff <= res_status_in;
      res_gain_ff   <= res_gain_in;
      res_freq_ff   <= res_freq_in;
      rsp_status_ff <= rsp_status_in;
      rsp_gain_ff   <= rsp_gain_in;
      rsp_freq_ff   <= rsp_freq_in;
   end

   `BNPGL_ASSERT_NOW(a_total_bound, band_total_ff <= BTW'(MAX_BANDS), "band count over limit")
   `BNPGL_ASSERT_NXT(a_accept_exec, req_fire, state_ff == S_EXEC, "accepted item not executed")
   `BNPGL_ASSERT_IMP(a_scan_range, state_ff == S_BAND_CHK, BTW'(scan_ff) < band_total_ff, "band scan past band count")
   `BNPGL_ASSERT_IMP(a_walk_range, state_ff == S_PT_CHK, PCW'(pt_k_ff) < cnt_sel, "point walk past table fill")

endmodule

// ===== test/tb_banded_nearest_point_gain_lookup.sv =====
// Self-checking testbench for the banded nearest point gain lookup.
`timescale 1ns / 1ps
module tb_banded_nearest_point_gain_lookup;
   import bnpgl_pkg::*;

   localparam int BAND_SLOTS = 8;
   localparam int POINT_SLOTS = 64;
   localparam int QUIET_LIMIT = 3000;
   localparam int F_MIN = 32'sh8000_0000;
   localparam int F_MAX = 32'sh7fff_ffff;
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   typedef struct {
      logic        [2:0]  cmd;
      logic        [2:0]  band_index;
      logic signed [31:0] lower_edge;
      logic signed [31:0] upper_edge;
      logic signed [31:0] point_freq;
      logic signed [15:0] point_gain;
      logic signed [31:0] query_freq;
   } lookup_req_type;

   typedef struct {
      logic        [2:0]  status;
      logic signed [15:0] gain;
      logic signed [31:0] matched_freq;
   } gain_reply_type;

   class gain_table_scoreboard;
      int             band_lo [BAND_SLOTS];
      int             band_hi [BAND_SLOTS];
      int             band_count;
      bit             has_table [BAND_SLOTS];
      int             npts [BAND_SLOTS];
      int             pt_freq [BAND_SLOTS * POINT_SLOTS];
      shortint        pt_gain [BAND_SLOTS * POINT_SLOTS];
      gain_reply_type expected_replies[$];
      int             errors;

      function new();
         errors = 0;
         clear_tables();
      endfunction

      function void clear_tables();
         band_count = 0;
         foreach (has_table[i]) begin
            has_table[i] = 1'b0;
            npts[i] = 0;
         end
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      function gain_reply_type lookup_gain(int q);
         gain_reply_type r;
         int hit, k, idx, prev;
         longint dprev, dnext;
         r.status = ST_NOT_FOUND;
         r.gain = '0;
         r.matched_freq = '0;
         hit = -1;
         for (k = 0; k < band_count; k++) begin
            if (q >= band_lo[k] && q <= band_hi[k]) begin
               hit = k;
               break;
            end
         end
         if (hit < 0 || !has_table[hit]) return r;
         r.status = ST_OK;
         if (npts[hit] == 0) return r;
         prev = hit * POINT_SLOTS;
         for (k = 0; k < npts[hit]; k++) begin
            idx = hit * POINT_SLOTS + k;
            if (pt_freq[idx] > q) begin
               dprev = longint'(q) - longint'(pt_freq[prev]);
               dnext = longint'(pt_freq[idx]) - longint'(q);
               if (dprev > dnext) prev = idx;
               break;
            end
            prev = idx;
            if (pt_freq[idx] == q) break;
         end
         r.gain = pt_gain[prev];
         r.matched_freq = pt_freq[prev];
         return r;
      endfunction

      function void log_request(lookup_req_type it);
         gain_reply_type e;
         int bi;
         e.status = ST_OK;
         e.gain = '0;
         e.matched_freq = '0;
         bi = int'(it.band_index);
         case (it.cmd)
            CMD_ADD_BAND: begin
               if (band_count >= BAND_SLOTS) begin
                  e.status = ST_BAND_FULL;
               end else begin
                  band_lo[band_count] = it.lower_edge;
                  band_hi[band_count] = it.upper_edge;
                  has_table[band_count] = 1'b0;
                  npts[band_count] = 0;
                  band_count++;
               end
            end
            CMD_ATTACH: begin
               if (bi >= band_count) e.status = ST_BAD_BAND;
               else has_table[bi] = 1'b1;
            end
            CMD_ADD_POINT: begin
               if (bi >= band_count || !has_table[bi]) begin
                  e.status = ST_BAD_BAND;
               end else if (npts[bi] >= POINT_SLOTS) begin
                  e.status = ST_TABLE_FULL;
               end else begin
                  pt_freq[bi * POINT_SLOTS + npts[bi]] = it.point_freq;
                  pt_gain[bi * POINT_SLOTS + npts[bi]] = it.point_gain;
                  npts[bi]++;
               end
            end
            CMD_QUERY: e = lookup_gain(it.query_freq);
            CMD_CLEAR: clear_tables();
            default: ;
         endcase
         expected_replies = {expected_replies, e};
      endfunction

      function void check_reply(logic [2:0] st, logic signed [15:0] g,
                                logic signed [31:0] f);
         gain_reply_type e;
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected item status %0d gain %0d freq %0d", $time, st, g, f);
            errors++;
            return;
         end
         e = expected_replies.pop_front();
         if (st !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            errors++;
         end
         if (g !== e.gain) begin
            $display("%0t: gain expected %0d actual %0d", $time, e.gain, g);
            errors++;
         end
         if (f !== e.matched_freq) begin
            $display("%0t: matched_freq expected %0d actual %0d", $time, e.matched_freq, f);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   items_sent;
   int   quiet_cycles;
   gain_table_scoreboard sb = new();

   bnpgl_req_if req_ch();
   bnpgl_rsp_if rsp_ch();

   banded_nearest_point_gain_lookup dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      lookup_req_type seen;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_reply(rsp_ch.status, rsp_ch.gain, rsp_ch.matched_freq);
         if (req_ch.valid && req_ch.ready) begin
            seen.cmd = req_ch.cmd;
            seen.band_index = req_ch.band_index;
            seen.lower_edge = req_ch.lower_edge;
            seen.upper_edge = req_ch.upper_edge;
            seen.point_freq = req_ch.point_freq;
            seen.point_gain = req_ch.point_gain;
            seen.query_freq = req_ch.query_freq;
            sb.log_request(seen);
         end
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("banded_nearest_point_gain_lookup regression: fail");
            $finish;
         end
      end
   end

   function automatic lookup_req_type req_of(logic [2:0] cmd, logic [2:0] bi, int a, int b,
                                             int g);
      lookup_req_type r;
      r.cmd = cmd;
      r.band_index = bi;
      r.lower_edge = $urandom;
      r.upper_edge = $urandom;
      r.point_freq = $urandom;
      r.point_gain = 16'($urandom);
      r.query_freq = $urandom;
      case (cmd)
         CMD_ADD_BAND: begin
            r.lower_edge = a;
            r.upper_edge = b;
         end
         CMD_ADD_POINT: begin
            r.point_freq = a;
            r.point_gain = 16'(g);
         end
         CMD_QUERY: r.query_freq = a;
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_item(lookup_req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.cmd = it.cmd;
      req_ch.band_index = it.band_index;
      req_ch.lower_edge = it.lower_edge;
      req_ch.upper_edge = it.upper_edge;
      req_ch.point_freq = it.point_freq;
      req_ch.point_gain = it.point_gain;
      req_ch.query_freq = it.query_freq;
      if (it.cmd <= CMD_CLEAR) items_sent++;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      req_ch.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic maybe_noise();
      if ($urandom_range(11) == 0)
         send_item(req_of(3'($urandom), 3'($urandom), $urandom, $urandom, $urandom));
   endtask

   // clear, build bands and tables, then query at stored points, band edges and random frequencies
   task automatic run_table_session();
      int nb, lo, hi, tmp, np, f, k, j, nq;
      int band_lo_sent [9];
      bit tabled [9];
      int edges[$];
      int freqs[$];
      send_item(req_of(CMD_CLEAR, 3'($urandom), 0, 0, 0));
      nb = ($urandom_range(6) == 0) ? 9 : $urandom_range(1, 6);
      for (k = 0; k < nb; k++) begin
         lo = int'($urandom_range(6000)) - 3000;
         hi = lo + int'($urandom_range(2500));
         if ($urandom_range(9) == 0) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
         end
         band_lo_sent[k] = lo;
         edges = {edges, lo};
         edges = {edges, hi};
         send_item(req_of(CMD_ADD_BAND, 3'($urandom), lo, hi, 0));
         maybe_noise();
      end
      for (k = 0; k < nb && k < BAND_SLOTS; k++) begin
         tabled[k] = ($urandom_range(4) != 0);
         if (tabled[k]) begin
            send_item(req_of(CMD_ATTACH, 3'(k), 0, 0, 0));
            if ($urandom_range(5) == 0) send_item(req_of(CMD_ATTACH, 3'(k), 0, 0, 0));
         end else if ($urandom_range(2) == 0) begin
            send_item(req_of(CMD_ADD_POINT, 3'(k), band_lo_sent[k], 0, $urandom));
         end
         maybe_noise();
      end
      for (k = 0; k < nb && k < BAND_SLOTS; k++) begin
         if (tabled[k]) begin
            np = ($urandom_range(19) == 0) ? POINT_SLOTS + 2 : $urandom_range(8);
            f = band_lo_sent[k] - 50 + int'($urandom_range(100));
            for (j = 0; j < np; j++) begin
               if ($urandom_range(19) == 0) f -= int'($urandom_range(500));
               else f += int'($urandom_range(1, 400));
               freqs = {freqs, f};
               send_item(req_of(CMD_ADD_POINT, 3'(k), f, 0, $urandom));
               if (np <= 8) maybe_noise();
            end
         end
      end
      nq = $urandom_range(4, 12);
      for (k = 0; k < nq; k++) begin
         case ($urandom_range(5))
            0: f = (freqs.size() > 0) ? freqs[$urandom_range(freqs.size() - 1)] : 0;
            1: f = ((freqs.size() > 0) ? freqs[$urandom_range(freqs.size() - 1)] : 0)
                   + int'($urandom_range(6)) - 3;
            2: begin
               if (freqs.size() > 1) begin
                  j = $urandom_range(freqs.size() - 2);
                  f = (freqs[j] + freqs[j + 1]) >>> 1;
               end else begin
                  f = 0;
               end
            end
            3: f = edges[$urandom_range(edges.size() - 1)] + int'($urandom_range(2)) - 1;
            4: f = $urandom;
            default: f = int'($urandom_range(8500)) - 3000;
         endcase
         send_item(req_of(CMD_QUERY, 3'($urandom), f, 0, 0));
         maybe_noise();
      end
   endtask

   initial begin
      int phase, target;
      reset = 1'b1;
      send_idle_pct = 7;
      recv_stall_pct = 56;
      items_sent = 0;
      quiet_cycles = 0;
      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_CLEAR;
      req_ch.band_index = '0;
      req_ch.lower_edge = '0;
      req_ch.upper_edge = '0;
      req_ch.point_freq = '0;
      req_ch.point_gain = '0;
      req_ch.query_freq = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(req_of(CMD_QUERY, 3'd0, F_MIN, 0, 0));
      send_item(req_of(CMD_ATTACH, 3'd0, 0, 0, 0));
      send_item(req_of(CMD_ADD_POINT, 3'd0, 0, 0, 0));
      send_item(req_of(CMD_ADD_BAND, 3'd0, F_MIN, F_MAX, 0));
      send_item(req_of(CMD_ADD_POINT, 3'd0, 0, 0, 0));
      send_item(req_of(CMD_QUERY, 3'd0, 0, 0, 0));
      send_item(req_of(CMD_ATTACH, 3'd0, 0, 0, 0));
      send_item(req_of(CMD_ATTACH, 3'd0, 0, 0, 0));
      send_item(req_of(CMD_QUERY, 3'd7, 5, 0, 0));
      send_item(req_of(CMD_ADD_POINT, 3'd0, F_MIN, 0, -32768));
      send_item(req_of(CMD_ADD_POINT, 3'd0, -100, 0, 100));
      send_item(req_of(CMD_ADD_POINT, 3'd0, 100, 0, -100));
      send_item(req_of(CMD_ADD_POINT, 3'd0, F_MAX, 0, 32767));
      send_item(req_of(CMD_QUERY, 3'd0, 0, 0, 0));
      send_item(req_of(CMD_QUERY, 3'd0, 100, 0, 0));
      send_item(req_of(CMD_QUERY, 3'd0, F_MAX, 0, 0));
      send_item(req_of(CMD_QUERY, 3'd0, F_MIN, 0, 0));
      send_item(req_of(CMD_QUERY, 3'd0, 1, 0, 0));
      send_item(req_of(CMD_ADD_BAND, 3'd1, 10, -10, 0));
      send_item(req_of(CMD_ATTACH, 3'd5, 0, 0, 0));
      send_item(req_of(CMD_ADD_POINT, 3'd1, 3, 0, 7));
      send_item(req_of(CMD_UNUSED, 3'd3, 0, 0, 0));
      send_item(req_of(CMD_CLEAR, 3'd0, 0, 0, 0));
      send_item(req_of(CMD_QUERY, 3'd0, 0, 0, 0));
      pause_until_drained();

      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 56 : 0;
         recv_stall_pct = (phase == 0) ? 56 : (phase == 1) ? 7 : 0;
         target = items_sent + 300;
         while (items_sent < target) run_table_session();
         pause_until_drained();
      end

      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("banded_nearest_point_gain_lookup regression: pass");
      end else begin
         $display("banded_nearest_point_gain_lookup regression: fail");
      end
      $finish;
   end

endmodule

// ===== banded_nearest_point_gain_lookup.f =====
+incdir+rtl/core
rtl/core/bnpgl_pkg.sv
rtl/core/bnpgl_req_if.sv
rtl/core/bnpgl_rsp_if.sv
rtl/core/bnpgl_ram.sv
rtl/core/banded_nearest_point_gain_lookup.sv
test/tb_banded_nearest_point_gain_lookup.sv
